[src/plsc_pkg.sv]
package plsc_pkg;

    // Fixed field widths
    localparam int MID_W      = 12;
    localparam int NS_W       = 7;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 15;
    localparam int INT_W      = 16;
    localparam int SPEED_W    = 8;
    localparam int PID_W      = 34;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = ((2 * SPEED_W + PID_W + 7) / 8) * 8;

    localparam int SPEED_MAX = 100;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIDPOINT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT  = 3'd5;

    // Register reset values
    localparam logic [MID_W-1:0]  RST_MIDPOINT     = 12'd455;
    localparam logic [NS_W-1:0]   RST_CRUISE_SPEED = 7'd40;
    localparam logic [GAIN_W-1:0] RST_PROP_GAIN    = 16'd3072;
    localparam logic [GAIN_W-1:0] RST_INTEG_GAIN   = 16'd246;
    localparam logic [GAIN_W-1:0] RST_DERIV_GAIN   = 16'd9600;
    localparam logic [LIM_W-1:0]  RST_INTEG_LIMIT  = 15'd1000;

    // Opcodes
    localparam logic OP_TOUCH = 1'b0;
    localparam logic OP_LIGHT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_INTEG,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_SUM,
        ST_SPEED,
        ST_SCALE,
        ST_EMIT
    } plsc_state_t;

endpackage

[src/pid_line_steering_controller.sv]
// Line-following steering controller.
// Input words arrive on s_tvalid/s_tready: s_tuser is the opcode (touch or light
// sample) and s_tdata carries the light reading. A touch word toggles the moving
// flag and returns one word with both wheels at cruise speed (or zero when
// stopping). A light word runs one PID step; while moving it returns one word
// with steered wheel speeds and the raw PID output, while stopped it returns
// nothing but still updates the integrator and last error.
// Results leave on m_tvalid/m_tready through an output register, so a new word
// is taken while a result still waits; a stalled receiver holds the result and
// the sequencer waits in its final step until the register frees.
// Sequence: a touch word goes from acceptance straight to the emit step; a light
// word passes through the error, integrator, P, I and D multiply, sum, speed,
// scale and emit steps. A light word on a stopped controller emits nothing and
// frees the sequencer after the sum step. s_tready is high only while the
// sequencer idles, so a new word is taken only once the last has left the
// sequencer. The light path is set by the sequencer steps around the single
// shared 17 x 16 bit multiplier, used once for each gain term.
// Reset (aresetn low, synchronous) stops the controller, clears integrator and
// last error, and loads the register defaults.
module pid_line_steering_controller
    import plsc_pkg::*;
#(
    parameter int SAMPLE_BITS    = 12,
    parameter int GAIN_FRAC_BITS = 12,
    localparam int IN_DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // sample
    input  logic [0:0]             s_tuser,   // opcode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // left_speed, right_speed, pid_output
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int ERR_W  = ((SAMPLE_BITS > MID_W) ? SAMPLE_BITS : MID_W) + 1;
    localparam int DIFF_W = ERR_W + 1;
    localparam int SUM_W  = ((ERR_W > INT_W) ? ERR_W : INT_W) + 1;
    localparam int OP_W   = (DIFF_W > INT_W) ? DIFF_W : INT_W;
    localparam int PROD_W = GAIN_W + 1 + OP_W;
    localparam int ACC_W  = (PROD_W + 2 > PID_W) ? PROD_W + 2 : PID_W;
    localparam int SP_W   = ACC_W + 4;
    localparam int SHIFT  = GAIN_FRAC_BITS + 2;
    localparam logic [SP_W-1:0] ROUND_BIAS = SP_W'((64'd1 << SHIFT) - 64'd1);
    localparam logic signed [SP_W-1:0] SP_MAX = SP_W'(SPEED_MAX);

    plsc_state_t state_reg, state_next;

    // Configuration
    logic [MID_W-1:0]  mid_reg;
    logic [NS_W-1:0]   ns_reg;
    logic [GAIN_W-1:0] pgain_reg, igain_reg, dgain_reg;
    logic [LIM_W-1:0]  lim_reg;

    // Controller state
    logic                    moving_reg, moving_next;
    logic signed [ERR_W-1:0] last_err_reg, last_err_next;
    logic signed [INT_W-1:0] integ_reg, integ_next;

    // Working registers
    logic [SAMPLE_BITS-1:0]   sample_reg, sample_next;
    logic                     touch_reg, touch_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [SP_W-1:0]   lnum_reg, lnum_next, rnum_reg, rnum_next;
    logic signed [SPEED_W-1:0] lspd_reg, lspd_next, rspd_reg, rspd_next;

    // Output register
    logic                      m_valid_reg, m_valid_next;
    logic signed [SPEED_W-1:0] left_reg, left_next, right_reg, right_next;
    logic signed [PID_W-1:0]   pid_reg, pid_next;

    // Shared multiplier
    logic signed [GAIN_W:0]   mul_a;
    logic signed [OP_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] product;

    logic                    s_fire;
    logic                    flip;
    logic signed [SUM_W-1:0] isum, ilim;
    logic signed [SP_W-1:0]  base, pid3, pid6;
    logic signed [SPEED_W-1:0] touch_spd;

    function automatic logic signed [SPEED_W-1:0] scale_speed(input logic signed [SP_W-1:0] n);
        logic signed [SP_W-1:0] q;
        begin
            // truncate toward zero, then saturate
            q = $signed(n + (n[SP_W-1] ? ROUND_BIAS : '0)) >>> SHIFT;
            if (q > SP_MAX) begin
                q = SP_MAX;
            end else if (q < -SP_MAX) begin
                q = -SP_MAX;
            end
            scale_speed = SPEED_W'(q);
        end
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - 2 * SPEED_W - PID_W){1'b0}},
                       pid_reg, right_reg, left_reg};

    assign flip = err_reg[ERR_W-1] ^ last_err_reg[ERR_W-1];
    assign isum = SUM_W'(integ_reg) + SUM_W'(err_reg);
    assign ilim = $signed(SUM_W'(lim_reg));

    assign base = $signed(SP_W'(ns_reg) << SHIFT);
    assign pid3 = (SP_W'(acc_reg) <<< 1) + SP_W'(acc_reg);
    assign pid6 = pid3 <<< 1;

    assign touch_spd = !moving_reg ? '0 :
                       (ns_reg > NS_W'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX) :
                       SPEED_W'(ns_reg);

    always_comb begin
        case (state_reg)
            ST_MUL_P: begin
                mul_a = $signed({1'b0, pgain_reg});
                mul_b = OP_W'(err_reg);
            end
            ST_MUL_I: begin
                mul_a = $signed({1'b0, igain_reg});
                mul_b = OP_W'(integ_reg);
            end
            default: begin
                mul_a = $signed({1'b0, dgain_reg});
                mul_b = OP_W'(diff_reg);
            end
        endcase
    end

    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        moving_next   = moving_reg;
        last_err_next = last_err_reg;
        integ_next    = integ_reg;
        sample_next   = sample_reg;
        touch_next    = touch_reg;
        err_next      = err_reg;
        diff_next     = diff_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        lnum_next     = lnum_reg;
        rnum_next     = rnum_reg;
        lspd_next     = lspd_reg;
        rspd_next     = rspd_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        left_next     = left_reg;
        right_next    = right_reg;
        pid_next      = pid_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    sample_next = s_tdata[SAMPLE_BITS-1:0];
                    touch_next  = (s_tuser[0] == OP_TOUCH);
                    if (s_tuser[0] == OP_TOUCH) begin
                        moving_next = !moving_reg;
                        state_next  = ST_EMIT;
                    end else begin
                        state_next = ST_ERR;
                    end
                end
            end
            ST_ERR: begin
                err_next   = $signed(ERR_W'({1'b0, sample_reg})) -
                             $signed(ERR_W'({1'b0, mid_reg}));
                state_next = ST_INTEG;
            end
            ST_INTEG: begin
                // a sign change drops the integrator and the old error
                if (flip) begin
                    integ_next = '0;
                    diff_next  = DIFF_W'(err_reg);
                end else begin
                    if (isum > ilim) begin
                        integ_next = INT_W'(ilim);
                    end else if (isum < -ilim) begin
                        integ_next = INT_W'(-ilim);
                    end else begin
                        integ_next = INT_W'(isum);
                    end
                    diff_next = DIFF_W'(err_reg) - DIFF_W'(last_err_reg);
                end
                last_err_next = err_reg;
                state_next    = ST_MUL_P;
            end
            ST_MUL_P: begin
                prod_next  = product;
                state_next = ST_MUL_I;
            end
            ST_MUL_I: begin
                acc_next   = ACC_W'(prod_reg);
                prod_next  = product;
                state_next = ST_MUL_D;
            end
            ST_MUL_D: begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                prod_next  = product;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                state_next = moving_reg ? ST_SPEED : ST_IDLE;
            end
            ST_SPEED: begin
                // a zero output falls through the second arm and gives cruise speed
                if (acc_reg[ACC_W-1]) begin
                    lnum_next = base - pid3;
                    rnum_next = base + pid6;
                end else begin
                    lnum_next = base - pid6;
                    rnum_next = base + pid3;
                end
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                lspd_next  = scale_speed(lnum_reg);
                rspd_next  = scale_speed(rnum_reg);
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the output register frees
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    if (touch_reg) begin
                        left_next  = touch_spd;
                        right_next = touch_spd;
                        pid_next   = '0;
                    end else begin
                        left_next  = lspd_reg;
                        right_next = rspd_reg;
                        pid_next   = PID_W'(acc_reg);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg      <= RST_MIDPOINT;
            ns_reg       <= RST_CRUISE_SPEED;
            pgain_reg    <= RST_PROP_GAIN;
            igain_reg    <= RST_INTEG_GAIN;
            dgain_reg    <= RST_DERIV_GAIN;
            lim_reg      <= RST_INTEG_LIMIT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MIDPOINT:     mid_reg   <= cfg_wdata[MID_W-1:0];
                REG_CRUISE_SPEED: ns_reg    <= cfg_wdata[NS_W-1:0];
                REG_PROP_GAIN:    pgain_reg <= cfg_wdata[GAIN_W-1:0];
                REG_INTEG_GAIN:   igain_reg <= cfg_wdata[GAIN_W-1:0];
                REG_DERIV_GAIN:   dgain_reg <= cfg_wdata[GAIN_W-1:0];
                REG_INTEG_LIMIT:  lim_reg   <= cfg_wdata[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            moving_reg   <= 1'b0;
            last_err_reg <= '0;
            integ_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            moving_reg   <= moving_next;
            last_err_reg <= last_err_next;
            integ_reg    <= integ_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        touch_reg  <= touch_next;
        err_reg    <= err_next;
        diff_reg   <= diff_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        lnum_reg   <= lnum_next;
        rnum_reg   <= rnum_next;
        lspd_reg   <= lspd_next;
        rspd_reg   <= rspd_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        pid_reg    <= pid_next;
    end

    a_touch_to_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser[0] == OP_TOUCH) |=> (state_reg == ST_EMIT))
        else $error("touch word did not go straight to emit");

    a_stopped_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM && !moving_reg) |=> (state_reg == ST_IDLE))
        else $error("stopped controller went on to speed computation");

    a_scale_only_moving: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCALE) |-> moving_reg)
        else $error("speed scaling while stopped");

    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && !m_valid_reg) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("free output register not loaded");

    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (left_reg <= SPEED_W'(SPEED_MAX) && left_reg >= -SPEED_W'(SPEED_MAX)
                         && right_reg <= SPEED_W'(SPEED_MAX)
                         && right_reg >= -SPEED_W'(SPEED_MAX)))
        else $error("wheel speed out of range");

endmodule
